@@ src/hlm_pkg.sv @@
// Shared types, constants and codes for the HMC leapfrog Metropolis step.
`default_nettype none
package hlm_pkg;

  localparam int FRAC_BITS_DEF    = 24;
  localparam int STEP_W           = 27;
  localparam int COUNT_W          = 8;
  localparam int ENERGY_W         = 40;
  localparam int PROD_W           = 64;
  localparam int K_W              = 4;
  localparam int DIV_BITS         = 8;
  localparam int DIV_CYCLES       = 5;
  localparam int DVD_W            = DIV_BITS * DIV_CYCLES;

  localparam logic [26:0]        LOG2E_Q26        = 27'd96817625;
  localparam logic [31:0]        LN2_Q32          = 32'd2977044472;
  localparam logic [COUNT_W-1:0] STEP_COUNT_RESET = 8'd40;
  localparam logic [K_W-1:0]     HORNER_TERMS     = 4'd12;

  typedef enum logic [0:0] {
    REG_STEP_SIZE  = 1'b0,
    REG_STEP_COUNT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] momentum_sample;
    logic [15:0]        uniform_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]   position;
    logic                 accepted;
    logic [ENERGY_W-1:0]  start_energy;
    logic [ENERGY_W-1:0]  end_energy;
    logic [31:0]          accept_total;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_XX, OP_MUL_PP, OP_E0, OP_E1, OP_MUL_P, OP_ADD_XH,
    OP_ADD_X, OP_MUL_X, OP_SUB_P, OP_MUL_D, OP_Y, OP_MUL_F, OP_G, OP_MUL_R,
    OP_T, OP_DIV, OP_R, OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e         op;
    logic [K_W-1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic               e_le;
    logic               d_big;
    logic               out_full;
    logic [COUNT_W-1:0] step_count;
  } dp_status_t;

endpackage
`default_nettype wire

@@ src/hlm_ctrl.sv @@
// Sequencer for the trajectory, energy and acceptance steps.
`default_nettype none
module hlm_ctrl
  import hlm_pkg::*;
(
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o
);

  typedef enum logic [26:0] {
    S_IDLE = 27'b1 << 0,  S_MXX0 = 27'b1 << 1,  S_MPP0 = 27'b1 << 2,
    S_E0   = 27'b1 << 3,  S_MPH  = 27'b1 << 4,  S_AXH  = 27'b1 << 5,
    S_LMX  = 27'b1 << 6,  S_LSP  = 27'b1 << 7,  S_LMP  = 27'b1 << 8,
    S_LAX  = 27'b1 << 9,  S_FMX  = 27'b1 << 10, S_FSP  = 27'b1 << 11,
    S_FMP  = 27'b1 << 12, S_FAX  = 27'b1 << 13, S_MXX1 = 27'b1 << 14,
    S_MPP1 = 27'b1 << 15, S_E1   = 27'b1 << 16, S_CHK  = 27'b1 << 17,
    S_MD   = 27'b1 << 18, S_Y    = 27'b1 << 19, S_MF   = 27'b1 << 20,
    S_G    = 27'b1 << 21, S_MR   = 27'b1 << 22, S_T    = 27'b1 << 23,
    S_DIV  = 27'b1 << 24, S_R    = 27'b1 << 25, S_FIN  = 27'b1 << 26
  } state_e;

  state_e             state_q, state_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [K_W-1:0]     k_q, k_d;
  logic [2:0]         div_q, div_d;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    div_d    = div_q;
    cmd_o.op = OP_NONE;
    cmd_o.k  = k_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          // A zero step count runs as a single step.
          cnt_d    = (status_i.step_count == '0) ? '0 : status_i.step_count - 1'b1;
          state_d  = S_MXX0;
        end
      end
      S_MXX0: begin cmd_o.op = OP_MUL_XX; state_d = S_MPP0; end
      S_MPP0: begin cmd_o.op = OP_MUL_PP; state_d = S_E0; end
      S_E0:   begin cmd_o.op = OP_E0;     state_d = S_MPH; end
      S_MPH:  begin cmd_o.op = OP_MUL_P;  state_d = S_AXH; end
      S_AXH: begin
        cmd_o.op = OP_ADD_XH;
        state_d  = (cnt_q == '0) ? S_FMX : S_LMX;
      end
      S_LMX:  begin cmd_o.op = OP_MUL_X;  state_d = S_LSP; end
      S_LSP:  begin cmd_o.op = OP_SUB_P;  state_d = S_LMP; end
      S_LMP:  begin cmd_o.op = OP_MUL_P;  state_d = S_LAX; end
      S_LAX: begin
        cmd_o.op = OP_ADD_X;
        cnt_d    = cnt_q - 1'b1;
        state_d  = (cnt_q == COUNT_W'(1)) ? S_FMX : S_LMX;
      end
      S_FMX:  begin cmd_o.op = OP_MUL_X;  state_d = S_FSP; end
      S_FSP:  begin cmd_o.op = OP_SUB_P;  state_d = S_FMP; end
      S_FMP:  begin cmd_o.op = OP_MUL_P;  state_d = S_FAX; end
      S_FAX:  begin cmd_o.op = OP_ADD_XH; state_d = S_MXX1; end
      S_MXX1: begin cmd_o.op = OP_MUL_XX; state_d = S_MPP1; end
      S_MPP1: begin cmd_o.op = OP_MUL_PP; state_d = S_E1; end
      S_E1:   begin cmd_o.op = OP_E1;     state_d = S_CHK; end
      S_CHK: begin
        // The exponential is needed only when energy rose by less than 32.
        state_d = (status_i.e_le || status_i.d_big) ? S_FIN : S_MD;
      end
      S_MD:   begin cmd_o.op = OP_MUL_D;  state_d = S_Y; end
      S_Y:    begin cmd_o.op = OP_Y;      state_d = S_MF; end
      S_MF:   begin cmd_o.op = OP_MUL_F;  state_d = S_G; end
      S_G: begin
        cmd_o.op = OP_G;
        k_d      = HORNER_TERMS;
        state_d  = S_MR;
      end
      S_MR:   begin cmd_o.op = OP_MUL_R;  state_d = S_T; end
      S_T: begin
        cmd_o.op = OP_T;
        div_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        div_d    = div_q + 1'b1;
        if (div_q == 3'(DIV_CYCLES - 1)) state_d = S_R;
      end
      S_R: begin
        cmd_o.op = OP_R;
        k_d      = k_q - 1'b1;
        state_d  = (k_q == K_W'(1)) ? S_FIN : S_MR;
      end
      S_FIN: begin
        if (!status_i.out_full) begin
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      div_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      div_q   <= div_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign busy_o     = (state_q != S_IDLE);

endmodule
`default_nettype wire

@@ src/hlm_datapath.sv @@
// Datapath: configuration, shared multiplier, leapfrog, energy, exp and output register.
`default_nettype none
module hlm_datapath
  import hlm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [0:0]         cfg_addr_i,
  input  wire  [STEP_W-1:0]  cfg_data_i,
  input  wire  in_item_t     in_data_i,
  input  wire  dp_cmd_t      cmd_i,
  output dp_status_t         status_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output out_item_t          out_data_o
);

  localparam int DW = FRAC_BITS + 5;
  localparam int AW = (DW > 32) ? DW : 32;
  localparam logic [ENERGY_W-1:0] D_LIMIT = ENERGY_W'(32) << FRAC_BITS;

  function automatic logic signed [31:0] sat32(logic signed [64:0] v);
    if (v > 65'sd2147483647)       return 32'sh7FFFFFFF;
    else if (v < -65'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  // base + or - round(prod / 2^s), half away from zero on the magnitude.
  function automatic logic signed [31:0] step_update(logic signed [31:0] base,
      logic [PROD_W-1:0] prod, logic neg, int unsigned s);
    logic [PROD_W-1:0]  q;
    logic signed [64:0] qs;
    logic signed [64:0] sum;
    q   = (prod + (PROD_W'(1) << (s - 1))) >> s;
    qs  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum = $signed({{33{base[31]}}, base}) + qs;
    return sat32(sum);
  endfunction

  function automatic logic [ENERGY_W-1:0] energy_of(logic [PROD_W-1:0] a,
      logic [PROD_W-1:0] b);
    logic [PROD_W:0] s;
    s = ({1'b0, a} + {1'b0, b} + ((PROD_W + 1)'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
    return (|s[PROD_W:ENERGY_W]) ? {ENERGY_W{1'b1}} : s[ENERGY_W-1:0];
  endfunction

  logic [STEP_W-1:0]   step_size_q;
  logic [COUNT_W-1:0]  step_count_q;
  logic signed [31:0]  chain_q, x_q, p_q;
  logic [31:0]         acc_cnt_q;
  logic [15:0]         u_q;
  logic [STEP_W-1:0]   dt_q;
  logic [PROD_W-1:0]   prod_q, sum_q;
  logic                neg_q;
  logic [ENERGY_W-1:0] e0_q, e1_q;
  logic [7:0]          n_q;
  logic [31:0]         f_q, g_q;
  logic [32:0]         r_q;
  logic [DVD_W-1:0]    dvd_q;
  logic [K_W-1:0]      rem_q;
  out_item_t           out_q;
  logic                out_valid_q;

  logic [31:0]          ax, ap;
  logic [AW-1:0]        mul_a;
  logic [32:0]          mul_b;
  logic [AW+32:0]       mul_full;
  logic [ENERGY_W-1:0]  d;
  logic [65:0]          y_full;
  logic [PROD_W:0]      t_full;
  logic [DVD_W-1:0]     dvd_next;
  logic [K_W-1:0]       rem_next;
  logic [K_W:0]         rem_try;
  logic [33:0]          e_round;
  logic [32:0]          e_val;
  logic                 acc;

  assign ax = x_q[31] ? 32'(-x_q) : 32'(x_q);
  assign ap = p_q[31] ? 32'(-p_q) : 32'(p_q);
  assign d  = e1_q - e0_q;

  always_comb begin
    mul_a = AW'(ax);
    mul_b = 33'(ax);
    case (cmd_i.op)
      OP_MUL_PP: begin mul_a = AW'(ap);            mul_b = 33'(ap); end
      OP_MUL_P:  begin mul_a = AW'(ap);            mul_b = 33'(dt_q); end
      OP_MUL_X:  begin mul_a = AW'(ax);            mul_b = 33'(dt_q); end
      OP_MUL_D:  begin mul_a = AW'(d[DW-1:0]);     mul_b = 33'(LOG2E_Q26); end
      OP_MUL_F:  begin mul_a = AW'(f_q);           mul_b = 33'(LN2_Q32); end
      OP_MUL_R:  begin mul_a = AW'(g_q);           mul_b = r_q; end
      default:   begin mul_a = AW'(ax);            mul_b = 33'(ax); end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  assign y_full = (66'(prod_q) << (32 - FRAC_BITS)) + (66'(1) << 25);
  assign t_full = ({1'b0, prod_q} + ((PROD_W + 1)'(1) << 31)) >> 32;

  // Eight restoring division steps a cycle by the small Horner divisor.
  always_comb begin
    dvd_next = dvd_q;
    rem_next = rem_q;
    rem_try  = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_try = {rem_next, dvd_next[DVD_W-1]};
      if (rem_try >= {1'b0, cmd_i.k}) begin
        rem_next = K_W'(rem_try - {1'b0, cmd_i.k});
        dvd_next = {dvd_next[DVD_W-2:0], 1'b1};
      end else begin
        rem_next = rem_try[K_W-1:0];
        dvd_next = {dvd_next[DVD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    e_round = '0;
    if (n_q >= 8'd40) begin
      e_val = '0;
    end else if (n_q == 8'd0) begin
      e_val = r_q;
    end else begin
      e_round = ({1'b0, r_q} + (34'(1) << (n_q[5:0] - 6'd1))) >> n_q[5:0];
      e_val   = e_round[32:0];
    end
    if (e1_q <= e0_q)     acc = 1'b1;
    else if (d >= D_LIMIT) acc = 1'b0;
    else                   acc = (e_val > {1'b0, u_q, 16'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_size_q  <= STEP_W'(64'd1 << FRAC_BITS);
      step_count_q <= STEP_COUNT_RESET;
      chain_q      <= '0;
      acc_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_addr_i))
          REG_STEP_SIZE:  step_size_q  <= cfg_data_i;
          REG_STEP_COUNT: step_count_q <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_FIN) begin
        out_valid_q <= 1'b1;
        if (acc) begin
          chain_q <= x_q;
          if (acc_cnt_q != 32'hFFFFFFFF) acc_cnt_q <= acc_cnt_q + 32'd1;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        x_q  <= chain_q;
        p_q  <= in_data_i.momentum_sample;
        u_q  <= in_data_i.uniform_sample;
        dt_q <= step_size_q;
      end
      OP_MUL_XX: prod_q <= mul_full[PROD_W-1:0];
      OP_MUL_PP: begin
        sum_q  <= prod_q;
        prod_q <= mul_full[PROD_W-1:0];
      end
      OP_E0: e0_q <= energy_of(sum_q, prod_q);
      OP_E1: e1_q <= energy_of(sum_q, prod_q);
      OP_MUL_P: begin
        prod_q <= mul_full[PROD_W-1:0];
        neg_q  <= p_q[31];
      end
      OP_MUL_X: begin
        prod_q <= mul_full[PROD_W-1:0];
        neg_q  <= x_q[31];
      end
      OP_ADD_XH: x_q <= step_update(x_q, prod_q, neg_q, FRAC_BITS + 1);
      OP_ADD_X:  x_q <= step_update(x_q, prod_q, neg_q, FRAC_BITS);
      OP_SUB_P:  p_q <= step_update(p_q, prod_q, !neg_q, FRAC_BITS);
      OP_MUL_D, OP_MUL_F, OP_MUL_R: prod_q <= mul_full[PROD_W-1:0];
      OP_Y: begin
        n_q <= y_full[65:58];
        f_q <= y_full[57:26];
      end
      OP_G: begin
        g_q <= prod_q[63:32];
        r_q <= 33'h100000000;
      end
      OP_T: begin
        dvd_q <= DVD_W'(t_full[32:0]) + DVD_W'(cmd_i.k >> 1);
        rem_q <= '0;
      end
      OP_DIV: begin
        dvd_q <= dvd_next;
        rem_q <= rem_next;
      end
      OP_R: r_q <= 33'h100000000 - dvd_q[32:0];
      OP_FIN: begin
        out_q.position     <= acc ? x_q : chain_q;
        out_q.accepted     <= acc;
        out_q.start_energy <= e0_q;
        out_q.end_energy   <= e1_q;
        out_q.accept_total <= (acc && acc_cnt_q != 32'hFFFFFFFF) ?
                              acc_cnt_q + 32'd1 : acc_cnt_q;
      end
      default: ;
    endcase
  end

  assign status_o.e_le       = (e1_q <= e0_q);
  assign status_o.d_big      = (d >= D_LIMIT);
  assign status_o.out_full   = out_valid_q && out_stall_i;
  assign status_o.step_count = step_count_q;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;

endmodule
`default_nettype wire

@@ src/hmc_leapfrog_metropolis_step.sv @@
// Top level of the HMC leapfrog Metropolis step: sequencer and datapath.
//
//   Channel  Direction  Handshake                Payload
//   cfg      in         cfg_we_i                 cfg_addr_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o  in_data_i (in_item_t)
//   out      out        out_valid_o / out_stall_i out_data_o (out_item_t)
//
// A request skips the exponential when energy does not rise or rises by 32 or more;
// otherwise the single shared multiplier also steps through the twelve Horner terms,
// each with a restoring divide.
// Reset clears the chain position, the acceptance count and the sequencer.
// A finished result waits in the output register; a new request is taken meanwhile,
// and the sequencer holds in its last step only if that register is still occupied.
`default_nettype none
module hmc_leapfrog_metropolis_step
  import hlm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [0:0]         cfg_addr_i,
  input  wire  [STEP_W-1:0]  cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  in_item_t     in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output out_item_t          out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       busy;

  hlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  hlm_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> busy)
    else $error("sequencer not busy after a request was taken");

  a_accept_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.accepted) |-> (out_data_o.accept_total != 32'd0))
    else $error("accepted trial with zero acceptance count");

  a_reject_energy_rose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.accepted) |->
      (out_data_o.end_energy > out_data_o.start_energy))
    else $error("trial rejected although energy did not rise");

endmodule
`default_nettype wire
